>>> rtl/qept_pkg.sv
// Shared types, constants and the transition decode table for the encoder tracker.
package qept_pkg;

    // Position and configuration widths
    localparam int POS_W  = 16;
    localparam int STEP_W = 15;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 3;

    // Number of encoder lanes
    localparam int NUM_ENC = 2;

    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic [STEP_W-1:0]       step_t;
    typedef logic [1:0]              pins_t;
    typedef pos_t                    pos_vec_t [NUM_ENC];
    typedef pins_t                   pins_vec_t [NUM_ENC];

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        CFG_STEP_SIZE       = 3'd0,
        CFG_UPPER_LIMIT     = 3'd1,
        CFG_LOWER_LIMIT     = 3'd2,
        CFG_WRAP_VALUE_HIGH = 3'd3,
        CFG_WRAP_VALUE_LOW  = 3'd4
    } cfg_idx_t;

    // Reset values of the configuration registers
    localparam step_t RST_STEP_SIZE  = STEP_W'(1024);
    localparam pos_t  RST_UPPER      = {1'b0, {(POS_W-1){1'b1}}};
    localparam pos_t  RST_LOWER      = {1'b1, {(POS_W-1){1'b0}}};
    localparam pos_t  RST_WRAP_HIGH  = '0;
    localparam pos_t  RST_WRAP_LOW   = '0;

    // Decoded movement of one encoder
    typedef enum logic [1:0] {
        MOVE_NONE = 2'd0,
        MOVE_TCW  = 2'd1,
        MOVE_TCCW = 2'd2
    } move_t;

    // Indexed [previous state][new state], state = {A, B}
    localparam move_t MOVE_TABLE [4][4] = '{
        '{MOVE_NONE, MOVE_TCW,  MOVE_TCCW, MOVE_NONE},
        '{MOVE_TCCW, MOVE_NONE, MOVE_NONE, MOVE_TCW },
        '{MOVE_TCW,  MOVE_NONE, MOVE_NONE, MOVE_TCCW},
        '{MOVE_NONE, MOVE_TCCW, MOVE_TCW,  MOVE_NONE}
    };

    // Limits and step shared by every lane
    typedef struct packed {
        step_t step_size;
        pos_t  upper_limit;
        pos_t  lower_limit;
        pos_t  wrap_value_high;
        pos_t  wrap_value_low;
    } cfg_t;

    // Per-transaction control broadcast to the lanes
    typedef struct packed {
        logic accept;
        logic clear;
        logic primed;
    } lane_ctrl_t;

endpackage

>>> rtl/qept_lane.sv
// One encoder lane: stored pin state, x4 decode and clamped position update.
module qept_lane
(
    input  logic                clk,
    input  logic                rst_n,
    input  qept_pkg::lane_ctrl_t ctrl,
    input  qept_pkg::cfg_t      cfg,
    input  qept_pkg::pins_t     pins,
    output qept_pkg::pos_t      count_next
);
    import qept_pkg::*;

    pins_t prev_pins_reg;
    pins_t prev_pins_next;
    pos_t  count_reg;
    move_t move;

    logic signed [POS_W:0] sum_up;
    logic signed [POS_W:0] sum_down;
    logic signed [POS_W:0] upper_wide;
    logic signed [POS_W:0] lower_wide;
    pos_t                  pos_up;
    pos_t                  pos_down;

    // Decode the transition from the stored state
    assign move = MOVE_TABLE[prev_pins_reg][pins];

    // Widened add and subtract so the clamp never sees an overflow
    assign sum_up   = $signed({count_reg[POS_W-1], count_reg})
                      + $signed({2'b00, cfg.step_size});
    assign sum_down = $signed({count_reg[POS_W-1], count_reg})
                      - $signed({2'b00, cfg.step_size});

    // Sign-extended limits for the signed clamp compares
    assign upper_wide = $signed({cfg.upper_limit[POS_W-1], cfg.upper_limit});
    assign lower_wide = $signed({cfg.lower_limit[POS_W-1], cfg.lower_limit});

    // Upward move: wrap load at the limit, otherwise saturate
    always_comb
    begin
        if (count_reg >= cfg.upper_limit)
        begin
            pos_up = cfg.wrap_value_high;
        end
        else if (sum_up > upper_wide)
        begin
            pos_up = cfg.upper_limit;
        end
        else
        begin
            pos_up = sum_up[POS_W-1:0];
        end
    end

    // Downward move mirrors the upward one
    always_comb
    begin
        if (count_reg <= cfg.lower_limit)
        begin
            pos_down = cfg.wrap_value_low;
        end
        else if (sum_down < lower_wide)
        begin
            pos_down = cfg.lower_limit;
        end
        else
        begin
            pos_down = sum_down[POS_W-1:0];
        end
    end

    // Next state; inverted sense: table counter-clockwise counts up
    always_comb
    begin
        count_next     = count_reg;
        prev_pins_next = prev_pins_reg;
        if (ctrl.accept)
        begin
            if (ctrl.clear)
            begin
                count_next = '0;
            end
            else
            begin
                prev_pins_next = pins;
                if (ctrl.primed)
                begin
                    case (move)
                        MOVE_TCCW: count_next = pos_up;
                        MOVE_TCW:  count_next = pos_down;
                        default:   count_next = count_reg;
                    endcase
                end
            end
        end
    end

    // Lane state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pins_reg <= '0;
            count_reg     <= '0;
        end
        else
        begin
            prev_pins_reg <= prev_pins_next;
            count_reg     <= count_next;
        end
    end

endmodule

>>> rtl/qept_out.sv
// Output stage: merges the lane positions into one registered result transaction.
module qept_out
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  qept_pkg::pos_vec_t pos_in,
    input  logic               out_stall,
    output logic               out_valid,
    output qept_pkg::pos_vec_t pos_out,
    output logic               busy
);
    import qept_pkg::*;

    logic     out_valid_reg;
    pos_vec_t pos_reg;

    // A waiting, stalled result blocks the next transaction
    assign busy      = out_valid_reg && out_stall;
    assign out_valid = out_valid_reg;
    assign pos_out   = pos_reg;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Position payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pos_reg <= pos_in;
        end
    end

endmodule

>>> rtl/quadrature_encoder_position_tracker.sv
// Top level of the two-encoder x4 quadrature position tracker.
// Takes one transaction of pin samples per clock and returns one transaction
// with both positions, registered, in the cycle after acceptance; a new sample is
// accepted every cycle unless a finished result is held stalled at the output.
// Both encoders are decoded and updated in parallel lanes.
// The first non-clear sample after reset only loads the stored pin states.
// Configuration writes take effect on the next clock and should be made idle.
module quadrature_encoder_position_tracker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [qept_pkg::IDX_W-1:0]    cfg_index,
    input  logic [qept_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          x_pin_a,
    input  logic                          x_pin_b,
    input  logic                          y_pin_a,
    input  logic                          y_pin_b,
    input  logic                          clear_positions,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [qept_pkg::POS_W-1:0] x_position,
    output logic signed [qept_pkg::POS_W-1:0] y_position
);
    import qept_pkg::*;

    cfg_t       cfg_reg;
    logic       primed_reg;
    logic       accept;
    logic       busy;
    lane_ctrl_t ctrl;
    pins_vec_t  pins;
    pos_vec_t   count_next;
    pos_vec_t   pos_out;

    // Handshake
    assign in_stall = busy;
    assign accept   = in_valid && !busy;

    assign ctrl.accept = accept;
    assign ctrl.clear  = clear_positions;
    assign ctrl.primed = primed_reg;

    assign pins[0] = {x_pin_a, x_pin_b};
    assign pins[1] = {y_pin_a, y_pin_b};

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_size       <= RST_STEP_SIZE;
            cfg_reg.upper_limit     <= RST_UPPER;
            cfg_reg.lower_limit     <= RST_LOWER;
            cfg_reg.wrap_value_high <= RST_WRAP_HIGH;
            cfg_reg.wrap_value_low  <= RST_WRAP_LOW;
        end
        else if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_STEP_SIZE:       cfg_reg.step_size       <= cfg_data[STEP_W-1:0];
                CFG_UPPER_LIMIT:     cfg_reg.upper_limit     <= cfg_data;
                CFG_LOWER_LIMIT:     cfg_reg.lower_limit     <= cfg_data;
                CFG_WRAP_VALUE_HIGH: cfg_reg.wrap_value_high <= cfg_data;
                CFG_WRAP_VALUE_LOW:  cfg_reg.wrap_value_low  <= cfg_data;
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // Primed after the first non-clear sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg <= 1'b0;
        end
        else if (accept && !clear_positions)
        begin
            primed_reg <= 1'b1;
        end
    end

    // Encoder lanes
    for (genvar e = 0; e < NUM_ENC; e++)
    begin : g_lane
        qept_lane u_lane
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .cfg        (cfg_reg),
            .pins       (pins[e]),
            .count_next (count_next[e])
        );
    end

    // Merge into the output register
    qept_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .pos_in    (count_next),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .pos_out   (pos_out),
        .busy      (busy)
    );

    assign x_position = pos_out[0];
    assign y_position = pos_out[1];

`ifndef SYNTHESIS
    // A clear transaction always yields zero positions
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && clear_positions)
            |=> (out_valid && x_position == '0 && y_position == '0))
        else $error("clear did not produce zero positions");

    // Every accepted transaction produces a result next cycle
    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
        else $error("accepted transaction produced no result");

    // Input is only held off by a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled with no result waiting");

    // Once primed, the tracker stays primed until reset
    a_primed_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(primed_reg))
        else $error("primed flag dropped");
`endif

endmodule

>>> dv/tb_quadrature_encoder_position_tracker.sv
// Self-checking testbench for the two-encoder quadrature position tracker.
module tb_quadrature_encoder_position_tracker;

    import qept_pkg::*;

    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 10;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int RANDOM_PER_PHASE = 110;

    localparam pos_t  POS_MAX  = pos_t'(16'h7FFF);
    localparam pos_t  POS_MIN  = pos_t'(16'h8000);
    localparam step_t STEP_MAX = '1;

    // Encoder motion requested from the stimulus side
    typedef enum int {
        TURN_STAY,
        TURN_UP,
        TURN_DOWN,
        TURN_JUMP
    } turn_t;

    // Receiver back-pressure patterns
    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_RUNS
    } stall_mode_t;

    typedef struct packed {
        pos_t x;
        pos_t y;
    } pos_pair_t;

    // Gray transition decode, [stored state][new state], state = {A, B}
    localparam move_t GRAY_DECODE [4][4] = '{
        '{MOVE_NONE, MOVE_TCW,  MOVE_TCCW, MOVE_NONE},
        '{MOVE_TCCW, MOVE_NONE, MOVE_NONE, MOVE_TCW },
        '{MOVE_TCW,  MOVE_NONE, MOVE_NONE, MOVE_TCCW},
        '{MOVE_NONE, MOVE_TCCW, MOVE_TCW,  MOVE_NONE}
    };

    // DUT signals
    logic               clk             = 1'b0;
    logic               rst_n           = 1'b0;
    logic               cfg_write       = 1'b0;
    logic [IDX_W-1:0]   cfg_index       = '0;
    logic [CFG_W-1:0]   cfg_data        = '0;
    logic               in_valid        = 1'b0;
    logic               in_stall;
    logic               x_pin_a         = 1'b0;
    logic               x_pin_b         = 1'b0;
    logic               y_pin_a         = 1'b0;
    logic               y_pin_b         = 1'b0;
    logic               clear_positions = 1'b0;
    logic               out_valid;
    logic               out_stall       = 1'b0;
    logic signed [POS_W-1:0] x_position;
    logic signed [POS_W-1:0] y_position;

    // Predictor state and configuration copy
    step_t      cur_step      = RST_STEP_SIZE;
    pos_t       cur_upper     = POS_MAX;
    pos_t       cur_lower     = POS_MIN;
    pos_t       cur_wrap_high = '0;
    pos_t       cur_wrap_low  = '0;
    pins_t      stored_pins [NUM_ENC] = '{default: 2'b00};
    pos_t       position    [NUM_ENC] = '{default: '0};
    logic       primed        = 1'b0;
    pos_pair_t  expected_positions [$];

    // Stimulus bookkeeping
    pins_t       walk_pins [NUM_ENC] = '{default: 2'b00};
    bit          gaps_on     = 1'b0;
    int          burst_left  = 0;
    stall_mode_t stall_mode  = STALL_NONE;
    int          run_left    = 0;
    logic        run_level   = 1'b0;
    int          mismatches  = 0;
    int          cycle_count = 0;

    quadrature_encoder_position_tracker DUT
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .x_pin_a         (x_pin_a),
        .x_pin_b         (x_pin_b),
        .y_pin_a         (y_pin_a),
        .y_pin_b         (y_pin_b),
        .clear_positions (clear_positions),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .x_position      (x_position),
        .y_position      (y_position)
    );

    always #CLK_HALF clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(posedge clk)
    begin
        case (stall_mode)
            STALL_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
            STALL_PERIODIC: out_stall <= ((cycle_count % 9) < 4);
            STALL_RUNS:
            begin
                if (run_left == 0)
                begin
                    run_level = ~run_level;
                    run_left  = run_level ? $urandom_range(1, 12) : $urandom_range(1, 6);
                end
                else
                begin
                    run_left--;
                end
                out_stall <= run_level;
            end
            default:        out_stall <= 1'b0;
        endcase
    end

    // Result checker: every result transaction against the oldest prediction
    always @(posedge clk)
    begin
        pos_pair_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_positions.size() == 0)
            begin
                $error("result with nothing pending: x_position %0d y_position %0d",
                       x_position, y_position);
                mismatches++;
            end
            else
            begin
                want = expected_positions.pop_front();
                if (x_position !== want.x)
                begin
                    $error("x_position expected %0d actual %0d", $signed(want.x), x_position);
                    mismatches++;
                end
                if (y_position !== want.y)
                begin
                    $error("y_position expected %0d actual %0d", $signed(want.y), y_position);
                    mismatches++;
                end
            end
        end
    end

    // Move up one step: wrap load at the top, otherwise wide add and clamp
    function automatic pos_t step_up(pos_t p);
        int sum;
        if (p >= cur_upper)
            return cur_wrap_high;
        sum = int'(p) + int'(cur_step);
        if (sum > int'(cur_upper))
            sum = int'(cur_upper);
        return pos_t'(sum);
    endfunction

    // Move down one step, mirror of step_up
    function automatic pos_t step_down(pos_t p);
        int diff;
        if (p <= cur_lower)
            return cur_wrap_low;
        diff = int'(p) - int'(cur_step);
        if (diff < int'(cur_lower))
            diff = int'(cur_lower);
        return pos_t'(diff);
    endfunction

    // Update the position model for one accepted sample, queue the result
    task automatic predict_positions(input pins_t x_now, input pins_t y_now, input logic clr);
        pins_t     now [NUM_ENC];
        pos_pair_t result;
        now[0] = x_now;
        now[1] = y_now;
        if (clr)
        begin
            for (int e = 0; e < NUM_ENC; e++)
                position[e] = '0;
        end
        else if (!primed)
        begin
            for (int e = 0; e < NUM_ENC; e++)
                stored_pins[e] = now[e];
            primed = 1'b1;
        end
        else
        begin
            for (int e = 0; e < NUM_ENC; e++)
            begin
                case (GRAY_DECODE[stored_pins[e]][now[e]])
                    MOVE_TCCW: position[e] = step_up(position[e]);
                    MOVE_TCW:  position[e] = step_down(position[e]);
                    default:   ;
                endcase
                stored_pins[e] = now[e];
            end
        end
        result.x = position[0];
        result.y = position[1];
        expected_positions.push_back(result);
    endtask

    // Pin state after one requested motion
    function automatic pins_t next_pins(pins_t p, turn_t t);
        case (t)
            TURN_UP:
                case (p)
                    2'b00:   return 2'b10;
                    2'b10:   return 2'b11;
                    2'b11:   return 2'b01;
                    default: return 2'b00;
                endcase
            TURN_DOWN:
                case (p)
                    2'b00:   return 2'b01;
                    2'b01:   return 2'b11;
                    2'b11:   return 2'b10;
                    default: return 2'b00;
                endcase
            TURN_JUMP: return p ^ 2'b11;
            default:   return p;
        endcase
    endfunction

    function automatic turn_t random_turn(int up_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < up_pct)
            return TURN_UP;
        else if (r < 84)
            return TURN_DOWN;
        else if (r < 92)
            return TURN_STAY;
        return TURN_JUMP;
    endfunction

    // Send one sample transaction; called at a rising edge, returns at acceptance
    task automatic send_sample(input pins_t x_now, input pins_t y_now, input logic clr);
        if (gaps_on && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        in_valid        <= 1'b1;
        x_pin_a         <= x_now[1];
        x_pin_b         <= x_now[0];
        y_pin_a         <= y_now[1];
        y_pin_b         <= y_now[0];
        clear_positions <= clr;
        do
            @(posedge clk);
        while (in_stall);
        predict_positions(x_now, y_now, clr);
        // a clear sample leaves the stored pins alone
        if (!clr)
        begin
            walk_pins[0] = x_now;
            walk_pins[1] = y_now;
        end
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic send_turn(input turn_t tx, input turn_t ty);
        send_sample(next_pins(walk_pins[0], tx), next_pins(walk_pins[1], ty), 1'b0);
    endtask

    // Stop sending and wait for every pending result
    task automatic settle_outputs();
        in_valid <= 1'b0;
        while (expected_positions.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all five registers back to back while idle
    task automatic program_config(input step_t step, input pos_t upper, input pos_t lower,
                                  input pos_t wrap_hi, input pos_t wrap_lo);
        cfg_idx_t         order [5];
        logic [CFG_W-1:0] value [5];
        order = '{CFG_STEP_SIZE, CFG_UPPER_LIMIT, CFG_LOWER_LIMIT,
                  CFG_WRAP_VALUE_HIGH, CFG_WRAP_VALUE_LOW};
        value = '{CFG_W'(step), upper, lower, wrap_hi, wrap_lo};
        settle_outputs();
        for (int i = 0; i < 5; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= order[i];
            cfg_data  <= value[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        @(posedge clk);
        cur_step      = step;
        cur_upper     = upper;
        cur_lower     = lower;
        cur_wrap_high = wrap_hi;
        cur_wrap_low  = wrap_lo;
    endtask

    // Random walk with direction bias flipping so that the limits get reached
    task automatic run_random_walk(input int count);
        int bias;
        int r;
        bias = 42;
        for (int i = 0; i < count; i++)
        begin
            if (i % 30 == 0)
                bias = $urandom_range(0, 1) ? 70 : 14;
            r = $urandom_range(0, 99);
            if (r < 3)
                send_sample(pins_t'($urandom_range(0, 3)), pins_t'($urandom_range(0, 3)), 1'b1);
            else if (r < 5)
                send_sample(pins_t'($urandom_range(0, 3)), pins_t'($urandom_range(0, 3)), 1'b0);
            else
                send_turn(random_turn(bias), random_turn(bias));
        end
        settle_outputs();
    endtask

    // Priming, clear before and after priming, single and double steps, reset config
    task automatic test_prime_and_clear();
        gaps_on    = 1'b0;
        stall_mode = STALL_NONE;
        send_sample(2'b11, 2'b11, 1'b1);
        send_sample(2'b01, 2'b10, 1'b0);
        repeat (4) send_turn(TURN_UP, TURN_DOWN);
        repeat (2) send_turn(TURN_DOWN, TURN_UP);
        send_turn(TURN_JUMP, TURN_STAY);
        send_turn(TURN_STAY, TURN_JUMP);
        send_sample(2'b00, 2'b11, 1'b1);
        send_turn(TURN_UP, TURN_UP);
        settle_outputs();
    endtask

    // Clamp and wrap at the full range, zero step, and upper below lower
    task automatic test_limit_extremes();
        gaps_on    = 1'b1;
        stall_mode = STALL_RANDOM;
        program_config(STEP_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MAX);
        repeat (3) send_turn(TURN_UP, TURN_DOWN);
        program_config('0, pos_t'(5), pos_t'(-5), pos_t'(3), pos_t'(-3));
        repeat (3) send_turn(TURN_DOWN, TURN_UP);
        repeat (2) send_turn(TURN_UP, TURN_DOWN);
        program_config(step_t'(7), pos_t'(-10), pos_t'(10), pos_t'(100), pos_t'(-100));
        repeat (4) send_turn(TURN_UP, TURN_DOWN);
        repeat (2) send_turn(TURN_DOWN, TURN_UP);
        settle_outputs();
    endtask

    task automatic test_random_defaults();
        gaps_on    = 1'b0;
        stall_mode = STALL_NONE;
        program_config(RST_STEP_SIZE, POS_MAX, POS_MIN, '0, '0);
        run_random_walk(RANDOM_PER_PHASE);
    endtask

    // Narrow window so that clamps and wrap loads happen often
    task automatic test_random_tight_limits();
        gaps_on    = 1'b1;
        stall_mode = STALL_RANDOM;
        program_config(step_t'($urandom_range(1, 60)), pos_t'($urandom_range(0, 200)),
                       -pos_t'($urandom_range(0, 200)), pos_t'($urandom_range(0, 65535)),
                       pos_t'($urandom_range(0, 65535)));
        run_random_walk(RANDOM_PER_PHASE);
    endtask

    task automatic test_random_full_range();
        gaps_on    = 1'b1;
        stall_mode = STALL_PERIODIC;
        program_config(step_t'($urandom_range(0, 32767)), pos_t'($urandom_range(0, 65535)),
                       pos_t'($urandom_range(0, 65535)), pos_t'($urandom_range(0, 65535)),
                       pos_t'($urandom_range(0, 65535)));
        run_random_walk(RANDOM_PER_PHASE);
    endtask

    // Large steps against the widest limits, sums beyond 16 bits
    task automatic test_random_large_steps();
        gaps_on    = 1'b1;
        stall_mode = STALL_RUNS;
        program_config(step_t'($urandom_range(16384, 32767)), POS_MAX, POS_MIN,
                       $urandom_range(0, 1) ? POS_MIN : POS_MAX,
                       $urandom_range(0, 1) ? POS_MAX : POS_MIN);
        run_random_walk(RANDOM_PER_PHASE);
    endtask

    task automatic test_random_inverted_limits();
        gaps_on    = 1'b1;
        stall_mode = STALL_RANDOM;
        program_config(step_t'($urandom_range(1, 300)), -pos_t'($urandom_range(1, 1000)),
                       pos_t'($urandom_range(1, 1000)), pos_t'($urandom_range(0, 65535)),
                       pos_t'($urandom_range(0, 65535)));
        run_random_walk(RANDOM_PER_PHASE);
    endtask

    // Sequence of tests
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_prime_and_clear();
        test_limit_extremes();
        test_random_defaults();
        test_random_tight_limits();
        test_random_full_range();
        test_random_large_steps();
        test_random_inverted_limits();
        settle_outputs();

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
